// ===== rtl/mpd_pkg.sv =====
// shared constants, types and state codes of the closest pair distance unit
package mpd_pkg;

   // coordinate and result widths
   localparam int CoordWidth       = 24;
   localparam int ProbeWidth       = 3 * CoordWidth;
   localparam int DiffWidth        = CoordWidth + 1;
   localparam int SqWidth          = 2 * CoordWidth + 1;
   localparam int SumWidth         = SqWidth + 1;
   localparam int DistWidth        = 25;
   localparam int RemWidth         = DistWidth + 3;
   localparam int StepCntWidth     = $clog2(DistWidth);
   localparam int RspDataWidth     = 32;
   localparam int DefaultMaxProbes = 16;

   // kind of an input word, carried on req_tuser
   localparam logic ModeProbe  = 1'b0;
   localparam logic ModeSystem = 1'b1;

   // sentinels for the empty batch
   localparam logic [SumWidth-1:0]  SqAllOnes   = '1;
   localparam logic [DistWidth-1:0] DistAllOnes = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_EMIT
   } mpd_state_type;

   // status of the distance pipeline
   typedef struct packed {
      logic busy;
      logic sum_valid;
   } mpd_pipe_status_type;

   // status of the square root unit
   typedef struct packed {
      logic busy;
      logic done;
   } mpd_root_status_type;

endpackage

// ===== rtl/mpd_probe_mem.sv =====
// probe atom store, one write and one registered read port
module mpd_probe_mem
   import mpd_pkg::*;
#(
   parameter int Depth     = DefaultMaxProbes,
   parameter int AddrWidth = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  logic [ProbeWidth-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AddrWidth-1:0]  rd_addr,
   output logic [ProbeWidth-1:0] rd_data
);

   logic [ProbeWidth-1:0] mem [Depth];
   logic [ProbeWidth-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mpd_dist_pipe.sv =====
// squared distance pipeline: difference, square, sum, one stage each
module mpd_dist_pipe
   import mpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  issue,
   input  logic [ProbeWidth-1:0] probe,
   input  logic [ProbeWidth-1:0] atom,
   output logic [SumWidth-1:0]   sum,
   output mpd_pipe_status_type   status
);

   logic                       mem_valid_ff;
   logic                       abs_valid_ff;
   logic                       sq_valid_ff;
   logic                       sum_valid_ff;
   logic [DiffWidth-1:0]       abs_in [3];
   logic [DiffWidth-1:0]       abs_ff [3];
   logic [SqWidth-1:0]         sq_in [3];
   logic [SqWidth-1:0]         sq_ff [3];
   logic [SumWidth-1:0]        sum_in;
   logic [SumWidth-1:0]        sum_ff;
   logic signed [DiffWidth-1:0] diff [3];
   logic [2*DiffWidth-1:0]     prod [3];

   // per-axis absolute difference
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = DiffWidth'(signed'(probe[a*CoordWidth +: CoordWidth]))
                 - DiffWidth'(signed'(atom[a*CoordWidth +: CoordWidth]));
         abs_in[a] = diff[a][DiffWidth-1] ? DiffWidth'(-diff[a]) : DiffWidth'(diff[a]);
      end
   end

   // per-axis square, magnitude is at most 2^24
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a]  = abs_ff[a] * abs_ff[a];
         sq_in[a] = prod[a][SqWidth-1:0];
      end
   end

   // sum of the three squares
   assign sum_in = SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= 1'b0;
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mem_valid_ff <= issue;
         abs_valid_ff <= mem_valid_ff;
         sq_valid_ff  <= abs_valid_ff;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      abs_ff <= abs_in;
      sq_ff  <= sq_in;
      sum_ff <= sum_in;
   end

   assign sum              = sum_ff;
   assign status.sum_valid = sum_valid_ff;
   assign status.busy      = mem_valid_ff | abs_valid_ff | sq_valid_ff | sum_valid_ff;

endmodule

// ===== rtl/mpd_isqrt.sv =====
// floor square root, one result bit per cycle
module mpd_isqrt
   import mpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SumWidth-1:0]  value,
   output logic [DistWidth-1:0] root,
   output mpd_root_status_type  status
);

   logic [SumWidth-1:0]     val_ff, val_in;
   logic [RemWidth-1:0]     rem_ff, rem_in;
   logic [DistWidth-1:0]    root_ff, root_in;
   logic [StepCntWidth-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [RemWidth-1:0]     rem_shift;
   logic [RemWidth-1:0]     trial;
   logic                    fits;

   // one digit step: bring down two bits, try root*4+1
   always_comb begin
      rem_shift = {rem_ff[RemWidth-3:0], val_ff[SumWidth-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = rem_shift >= trial;
   end

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[SumWidth-3:0], 2'b00};
         rem_in  = fits ? rem_shift - trial : rem_shift;
         root_in = {root_ff[DistWidth-2:0], fits};
         cnt_in  = cnt_ff + StepCntWidth'(1);
         if (cnt_ff == StepCntWidth'(DistWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root          = root_ff;
   assign status.busy   = busy_ff;
   assign status.done   = done_ff;

endmodule

// ===== rtl/min_pairwise_point_distance_unit.sv =====
// top level of the probe to system atom closest pair distance unit
//
//  channel  dir  words                         sidebands
//  req_     in   tdata {z, y, x} 3 x 24 bits   tuser mode, tlast last atom
//  rsp_     out  tdata min distance, 25 bits   tuser probes dropped
//
// a system word scans the N stored probes, one probe memory read per cycle
// feeding the distance pipeline of difference, square and sum stages, and
// drains that pipeline. the last system word goes on to run the bit-serial
// square root (25 steps, then a done flag) and loads the result register.
// reset is synchronous and clears the control state; the probe memory needs
// no clearing pass. a held result blocks new words only once the next result
// waits to be loaded.
module min_pairwise_point_distance_unit
   import mpd_pkg::*;
#(
   parameter int MAX_PROBES = DefaultMaxProbes
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ProbeWidth-1:0]   req_tdata,   // x_coord, y_coord, z_coord
   input  logic                    req_tuser,   // mode
   input  logic                    req_tlast,   // last_atom
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // min_distance, zero pad
   output logic                    rsp_tuser    // probes_dropped
);

   localparam int CntWidth  = $clog2(MAX_PROBES + 1);
   localparam int AddrWidth = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

   mpd_state_type         state_ff, state_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic [CntWidth-1:0]   idx_ff, idx_in;
   logic [SumWidth-1:0]   best_ff, best_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff;
   logic [ProbeWidth-1:0] atom_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DistWidth-1:0]  rsp_dist_ff;
   logic                  rsp_drop_ff;

   logic                  req_accept;
   logic                  probe_accept;
   logic                  probe_store;
   logic                  system_accept;
   logic                  rd_en;
   logic                  root_start;
   logic                  emit_load;
   logic                  scan_end;
   logic [ProbeWidth-1:0] rd_data;
   logic [SumWidth-1:0]   sum;
   logic [DistWidth-1:0]  root;
   mpd_pipe_status_type   pipe_status;
   mpd_root_status_type   root_status;

   assign req_accept    = req_tvalid & req_tready;
   assign probe_accept  = req_accept & (req_tuser == ModeProbe);
   assign system_accept = req_accept & (req_tuser == ModeSystem);
   assign probe_store   = probe_accept & (count_ff < CntWidth'(MAX_PROBES));
   assign scan_end      = (idx_ff + CntWidth'(1)) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (system_accept) begin
               state_in = (count_ff == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_status.busy) begin
               state_in = last_ff ? ST_ROOT : ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (root_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      root_start = 1'b0;
      emit_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_SCAN:  rd_en      = 1'b1;
         ST_DRAIN: root_start = !pipe_status.busy && last_ff;
         ST_EMIT:  emit_load  = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // batch bookkeeping and running minimum
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      best_in  = best_ff;
      idx_in   = idx_ff;
      if (emit_load) begin
         count_in = '0;
         ovf_in   = 1'b0;
         best_in  = SqAllOnes;
      end else begin
         if (probe_store) begin
            count_in = count_ff + CntWidth'(1);
         end else if (probe_accept) begin
            ovf_in = 1'b1;
         end
         if (pipe_status.sum_valid && (sum < best_ff)) begin
            best_in = sum;
         end
      end
      if (system_accept) begin
         idx_in = '0;
      end else if (rd_en) begin
         idx_in = idx_ff + CntWidth'(1);
      end
   end

   // result register
   assign rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         best_ff      <= SqAllOnes;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured system atom and result payload
   always_ff @(posedge clock) begin
      if (system_accept) begin
         atom_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (emit_load) begin
         rsp_dist_ff <= (best_ff == SqAllOnes) ? DistAllOnes : root;
         rsp_drop_ff <= ovf_ff;
      end
   end

   mpd_probe_mem #(
      .Depth     (MAX_PROBES),
      .AddrWidth (AddrWidth)
   ) u_mem (
      .clock   (clock),
      .wr_en   (probe_store),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   mpd_dist_pipe u_pipe (
      .clock  (clock),
      .reset  (reset),
      .issue  (rd_en),
      .probe  (rd_data),
      .atom   (atom_ff),
      .sum    (sum),
      .status (pipe_status)
   );

   mpd_isqrt u_root (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .value  (best_ff),
      .root   (root),
      .status (root_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataWidth'(rsp_dist_ff);
   assign rsp_tuser  = rsp_drop_ff;

endmodule

// ===== rtl/mpd_checker.sv =====
// port-level checks of the closest pair distance unit, bound to the top level
module mpd_checker
   import mpd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    req_tuser,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tuser
);

   // a stalled result holds its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // pad bits above the distance stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataWidth-1:DistWidth] == '0)
      else $error("result pad bits not zero");

   // a system word always blocks the input for its scan
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ModeSystem) |=> !req_tready)
      else $error("input ready right after a system word");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind min_pairwise_point_distance_unit mpd_checker u_checker (.*);

// ===== sim/tb_top.sv =====
// testbench for the probe to system atom closest pair distance unit
module tb_top
   import mpd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int      ClockPeriod   = 20;
   localparam int      ProbeCapacity = DefaultMaxProbes;
   localparam int      DrainCycles   = 64;
   localparam longint  LimitCycles   = 1_000_000;

   typedef struct {
      logic [DistWidth-1:0] distance;
      logic                 dropped;
   } result_word_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ProbeWidth-1:0]   req_tdata;   // x_coord, y_coord, z_coord
   logic                    req_tuser;   // mode
   logic                    req_tlast;   // last_atom
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;   // min_distance, zero pad
   logic                    rsp_tuser;   // probes_dropped

   // expected results, oldest first
   result_word_type expected_dist_q[$];
   int           fail_count       = 0;
   int           send_idle_pct    = 0;
   int           recv_idle_pct    = 0;
   int           hold_off_cycles  = 0;
   int           words_sent       = 0;

   // shadow copy of the batch state
   int               probe_x[ProbeCapacity];
   int               probe_y[ProbeCapacity];
   int               probe_z[ProbeCapacity];
   int               probe_total  = 0;
   longint unsigned  best_sq      = SqAllOnes;
   bit               dropped_flag = 1'b0;

   min_pairwise_point_distance_unit #(
      .MAX_PROBES(ProbeCapacity)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // run limit
   initial begin
      #(LimitCycles * ClockPeriod);
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic longint unsigned sq_of(int d);
      longint v;
      v = d;
      return v * v;
   endfunction

   // floor square root, one result bit per step from the top
   function automatic logic [DistWidth-1:0] floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = DistWidth - 1; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r[DistWidth-1:0];
   endfunction

   // update the shadow batch state with one accepted word
   task automatic apply_atom(logic mode, logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] y,
                             logic [CoordWidth-1:0] z, logic last);
      int              ax;
      int              ay;
      int              az;
      longint unsigned s;
      result_word_type res;
      ax = $signed(x);
      ay = $signed(y);
      az = $signed(z);
      if (mode == ModeProbe) begin
         if (probe_total < ProbeCapacity) begin
            probe_x[probe_total] = ax;
            probe_y[probe_total] = ay;
            probe_z[probe_total] = az;
            probe_total++;
         end else begin
            dropped_flag = 1'b1;
         end
         return;
      end
      for (int i = 0; i < probe_total; i++) begin
         s = sq_of(probe_x[i] - ax) + sq_of(probe_y[i] - ay) + sq_of(probe_z[i] - az);
         if (s < best_sq) best_sq = s;
      end
      if (!last) return;
      // batch end: emit and clear
      res.distance = (best_sq == SqAllOnes) ? DistAllOnes : floor_root(best_sq);
      res.dropped  = dropped_flag;
      expected_dist_q.push_back(res);
      probe_total  = 0;
      best_sq      = SqAllOnes;
      dropped_flag = 1'b0;
   endtask

   // offer one word and wait until it is taken
   task automatic send_word(logic mode, logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] y,
                            logic [CoordWidth-1:0] z, logic last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tuser  <= mode;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      apply_atom(mode, x, y, z, last);
   endtask

   // drop valid and wait until every expected result has come
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_dist_q.size() != 0) @(posedge clock);
   endtask

   task automatic compare_result();
      result_word_type exp_res;
      if (expected_dist_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected result word: min_distance %h probes_dropped %b",
                     rsp_tdata[DistWidth-1:0], rsp_tuser);
         return;
      end
      exp_res = expected_dist_q.pop_front();
      if (rsp_tdata[DistWidth-1:0] !== exp_res.distance || rsp_tuser !== exp_res.dropped) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: min_distance exp %h got %h, probes_dropped exp %b got %b",
                     exp_res.distance, rsp_tdata[DistWidth-1:0], exp_res.dropped, rsp_tuser);
      end
   endtask

   // result side: check taken words, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) compare_result();
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [CoordWidth-1:0] pick_coord(logic [CoordWidth-1:0] center,
                                                        int spread);
      if (spread == 0) return CoordWidth'($urandom());
      return CoordWidth'(center + $urandom_range(2 * spread) - spread);
   endfunction

   // one batch of probes and system atoms, final system word closes it
   task automatic send_batch(int n_probe, int n_system, bit shuffled);
      logic [CoordWidth-1:0] cx;
      logic [CoordWidth-1:0] cy;
      logic [CoordWidth-1:0] cz;
      logic [CoordWidth-1:0] px;
      logic [CoordWidth-1:0] py;
      logic [CoordWidth-1:0] pz;
      logic                  mode;
      int                    spread;
      int                    probes_left;
      int                    sys_mid;
      int                    total;
      cx = CoordWidth'($urandom());
      cy = CoordWidth'($urandom());
      cz = CoordWidth'($urandom());
      px = cx;
      py = cy;
      pz = cz;
      case ($urandom_range(3))
         0:       spread = 0;
         1:       spread = 4;
         2:       spread = 300;
         default: spread = 40000;
      endcase
      probes_left = n_probe;
      sys_mid     = n_system - 1;
      total       = n_probe + n_system;
      for (int i = 0; i < total; i++) begin
         if (i == total - 1 || probes_left == 0) mode = ModeSystem;
         else if (sys_mid == 0) mode = ModeProbe;
         else if (shuffled) mode = $urandom_range(1) ? ModeSystem : ModeProbe;
         else mode = ModeProbe;
         if (mode == ModeProbe) begin
            probes_left--;
            px = pick_coord(cx, spread);
            py = pick_coord(cy, spread);
            pz = pick_coord(cz, spread);
            // last flag on a probe must be ignored
            send_word(ModeProbe, px, py, pz, $urandom_range(9) == 0);
         end else begin
            if (i != total - 1) sys_mid--;
            // a copy of the latest probe gives a zero distance when that probe was stored
            if ($urandom_range(9) == 0)
               send_word(ModeSystem, px, py, pz, i == total - 1);
            else
               send_word(ModeSystem, pick_coord(cx, spread), pick_coord(cy, spread),
                         pick_coord(cz, spread), i == total - 1);
         end
      end
   endtask

   // farthest corners of the coordinate range, all input bits at both values
   task automatic test_extremes();
      send_word(ModeProbe, 24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_word(ModeSystem, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
   endtask

   // system atom with no probe stored gives the all-ones distance
   task automatic test_empty_batch();
      send_word(ModeSystem, CoordWidth'($urandom()), CoordWidth'($urandom()),
                CoordWidth'($urandom()), 1'b1);
   endtask

   // two system atoms at the same distance, then an exact hit
   task automatic test_ties_and_zero();
      send_word(ModeProbe, 24'h000010, 24'hFFFFF0, 24'h123456, 1'b0);
      send_word(ModeSystem, 24'h000011, 24'hFFFFF0, 24'h123456, 1'b0);
      send_word(ModeSystem, 24'h00000F, 24'hFFFFF0, 24'h123456, 1'b1);
      send_word(ModeProbe, 24'h3A5C01, 24'hC0FFEE, 24'h000000, 1'b0);
      send_word(ModeSystem, 24'h3A5C01, 24'hC0FFEE, 24'h000000, 1'b1);
   endtask

   // one probe more than the store holds, one probe carrying the last flag
   task automatic test_store_full();
      for (int i = 0; i <= ProbeCapacity; i++)
         send_word(ModeProbe, CoordWidth'($urandom()), CoordWidth'($urandom()),
                   CoordWidth'($urandom()), i == 4);
      send_word(ModeSystem, CoordWidth'($urandom()), CoordWidth'($urandom()),
                CoordWidth'($urandom()), 1'b1);
   endtask

   // result side held off while short batches keep coming, then a full pause
   task automatic test_backpressure();
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      hold_off_cycles = 400;
      for (int i = 0; i < 8; i++) send_batch(1 + (i % 3), 1, 1'b0);
      wait_all_results();
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int n_words);
      int n_probe;
      int n_system;
      int r;
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at       = words_sent + n_words;
      while (words_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 8) n_probe = 0;
         else if (r < 20) n_probe = $urandom_range(ProbeCapacity + 4, ProbeCapacity + 1);
         else n_probe = $urandom_range(ProbeCapacity, 1);
         n_system = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
         send_batch(n_probe, n_system, $urandom_range(4) == 0);
      end
   endtask

   // main sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ModeProbe;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_empty_batch();
      test_ties_and_zero();
      test_store_full();
      test_random_traffic(30, 69, 620);
      test_backpressure();
      test_random_traffic(69, 30, 620);
      test_random_traffic(0, 0, 620);

      wait_all_results();
      repeat (DrainCycles) @(posedge clock);
      if (expected_dist_q.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mpd_pkg.sv
rtl/mpd_probe_mem.sv
rtl/mpd_dist_pipe.sv
rtl/mpd_isqrt.sv
rtl/min_pairwise_point_distance_unit.sv
rtl/mpd_checker.sv
sim/tb_top.sv
